[hdl/qmtf_pkg.sv]
// ----------------------------------------------------------------------------
// qmtf_pkg
// shared types and constants for the move-to-front/rear key queue
// ----------------------------------------------------------------------------
package qmtf_pkg;

   // request field widths
   localparam int MODE_W      = 2;
   localparam int REQ_KEY_W   = 16;
   // result field widths
   localparam int HEAD_KEY_W  = 16;
   localparam int COUNT_OUT_W = 5;

   // operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_ENQUEUE   = 2'd0,
      MODE_DEQUEUE   = 2'd1,
      MODE_MOVE_HEAD = 2'd2,
      MODE_MOVE_TAIL = 2'd3
   } mode_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic     accept;     // request transfer this cycle
      mode_type mode;
      logic     found;      // some cell holds the searched key
      logic     not_full;
      logic     not_empty;
   } cell_ctrl_type;

endpackage

[hdl/qmtf_cell.sv]
// ----------------------------------------------------------------------------
// qmtf_cell
// one queue slot: holds a key, compares it and shifts with its neighbors
// ----------------------------------------------------------------------------
module qmtf_cell #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16,
   parameter int INDEX    = 0,
   localparam int CW      = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  qmtf_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [CW-1:0]         count,
   input  logic [KEY_BITS-1:0]   prev_key,     // key of the cell nearer the front
   input  logic [KEY_BITS-1:0]   next_key,     // key of the cell nearer the rear
   input  logic                  match_prior,  // a cell nearer the front matched
   output logic                  match_out,
   output logic [KEY_BITS-1:0]   key,
   output logic [KEY_BITS-1:0]   key_next
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                in_use;
   logic                is_tail;
   logic                is_last;
   logic                own_match;

   assign in_use    = count > CW'(INDEX);
   assign is_tail   = count == CW'(INDEX);
   assign is_last   = count == CW'(INDEX + 1);
   assign own_match = in_use && (key_ff == req_key);
   assign match_out = match_prior || own_match;

   always_comb begin
      key_in = key_ff;
      if (ctrl.accept) begin
         unique case (ctrl.mode)
            qmtf_pkg::MODE_ENQUEUE: begin
               if (ctrl.not_full && is_tail) key_in = req_key;
            end
            qmtf_pkg::MODE_DEQUEUE: begin
               if (ctrl.not_empty) key_in = next_key;
            end
            qmtf_pkg::MODE_MOVE_HEAD: begin
               // cells from the front up to the first match shift rearward
               if (ctrl.found && !match_prior) begin
                  key_in = (INDEX == 0) ? req_key : prev_key;
               end
            end
            qmtf_pkg::MODE_MOVE_TAIL: begin
               // cells from the first match to the rear shift frontward
               if (ctrl.found && match_out) begin
                  key_in = is_last ? req_key : next_key;
               end
            end
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key      = key_ff;
   assign key_next = key_in;

endmodule

[hdl/queue_with_move_to_front_rear.sv]
// ----------------------------------------------------------------------------
// queue_with_move_to_front_rear
// bounded key queue with enqueue, dequeue, move-to-front and move-to-rear
// ----------------------------------------------------------------------------
// A row of DEPTH cells holds the queue, front in cell 0. On every request
// transfer, all cells compare their key with the request key at once, the
// first match (nearest the front) is picked by a flag that ripples down
// the row, and each cell loads its own key, a neighbor's key or the
// request key. One request is taken per cycle while req_stall is low; the
// path that sets the clock is the match ripple through all DEPTH cells. The
// result for a request sits in an output register the cycle after its
// transfer; a new request is taken while that result is taken or while the
// output register is empty, so back-to-back results leave at one per cycle.
// Keys are compared on their low KEY_BITS bits (at most 16 of the request).
// There is no reset pass: slot contents are undefined until written, and only
// slots below the entry count are ever looked at.
// ----------------------------------------------------------------------------
module queue_with_move_to_front_rear #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [qmtf_pkg::MODE_W-1:0]        req_mode,
   input  logic [qmtf_pkg::REQ_KEY_W-1:0]     req_key,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [qmtf_pkg::HEAD_KEY_W-1:0]    rsp_head_key,
   output logic                               rsp_is_empty,
   output logic [qmtf_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                               rsp_key_found,
   output logic                               rsp_overflow
);

   localparam int CW = $clog2(DEPTH + 1);

   // occupancy and result registers
   logic [CW-1:0]                            count_ff, count_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [qmtf_pkg::HEAD_KEY_W-1:0]          head_ff, head_in;
   logic                                     empty_ff, empty_in;
   logic [qmtf_pkg::COUNT_OUT_W-1:0]         cnt_out_ff, cnt_out_in;
   logic                                     found_ff, found_in;
   logic                                     ovf_ff, ovf_in;

   logic                                     accept;
   qmtf_pkg::mode_type                       mode;
   qmtf_pkg::cell_ctrl_type                  ctrl;
   logic [KEY_BITS-1:0]                      key_eff;
   logic [63:0]                              key_wide;
   logic [63:0]                              head_wide;
   logic [31:0]                              count_wide;
   logic                                     is_move;

   // cell row wiring
   logic [KEY_BITS-1:0]                      cell_key  [DEPTH];
   logic [KEY_BITS-1:0]                      cell_next [DEPTH];
   logic [DEPTH:0]                           match_chain;

   // output register frees up when empty or when its result transfers
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign mode      = qmtf_pkg::mode_type'(req_mode);

   // only the low KEY_BITS of the 16-bit request key take part
   assign key_wide = 64'(req_key);
   assign key_eff  = key_wide[KEY_BITS-1:0];

   assign is_move = (mode == qmtf_pkg::MODE_MOVE_HEAD) || (mode == qmtf_pkg::MODE_MOVE_TAIL);

   always_comb begin
      ctrl.accept    = accept;
      ctrl.mode      = mode;
      ctrl.found     = match_chain[DEPTH];
      ctrl.not_full  = count_ff != CW'(DEPTH);
      ctrl.not_empty = count_ff != '0;
   end

   assign match_chain[0] = 1'b0;

   // row of cells, front at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] prev_k;
      logic [KEY_BITS-1:0] next_k;
      if (i == 0) begin : g_first
         assign prev_k = cell_key[i];
      end else begin : g_mid
         assign prev_k = cell_key[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign next_k = cell_key[i];
      end else begin : g_inner
         assign next_k = cell_key[i+1];
      end
      qmtf_cell #(
         .DEPTH    (DEPTH),
         .KEY_BITS (KEY_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .req_key     (key_eff),
         .count       (count_ff),
         .prev_key    (prev_k),
         .next_key    (next_k),
         .match_prior (match_chain[i]),
         .match_out   (match_chain[i+1]),
         .key         (cell_key[i]),
         .key_next    (cell_next[i])
      );
   end

   // count update and result assembly
   always_comb begin
      count_in = count_ff;
      ovf_in   = 1'b0;
      unique case (mode)
         qmtf_pkg::MODE_ENQUEUE: begin
            if (ctrl.not_full) count_in = count_ff + CW'(1);
            else               ovf_in   = 1'b1;
         end
         qmtf_pkg::MODE_DEQUEUE: begin
            if (ctrl.not_empty) count_in = count_ff - CW'(1);
         end
         default: count_in = count_ff;
      endcase
      found_in   = is_move && ctrl.found;
      head_wide  = 64'(cell_next[0]);
      head_in    = (count_in != '0) ? head_wide[qmtf_pkg::HEAD_KEY_W-1:0] : '0;
      empty_in   = count_in == '0;
      count_wide = 32'(count_in);
      cnt_out_in = count_wide[qmtf_pkg::COUNT_OUT_W-1:0];
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
      if (accept) begin
         head_ff    <= head_in;
         empty_ff   <= empty_in;
         cnt_out_ff <= cnt_out_in;
         found_ff   <= found_in;
         ovf_ff     <= ovf_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_head_key    = head_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_key_found   = found_ff;
   assign rsp_overflow    = ovf_ff;

   // occupancy never exceeds the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // every request transfer yields a result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("result missing after request transfer");

   // enqueue on a full queue is flagged and leaves the count unchanged
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == qmtf_pkg::MODE_ENQUEUE && !ctrl.not_full)
      |=> (rsp_overflow && count_ff == $past(count_ff)))
      else $error("overflow not reported");

   // dequeue on a non-empty queue removes exactly one entry
   a_dequeue: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == qmtf_pkg::MODE_DEQUEUE && ctrl.not_empty)
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("dequeue count mismatch");

endmodule
